// ===== hw/rtl/ptodo_pkg.sv =====
// ----------------------------------------------------------------------------
// ptodo_pkg
// Shared types, widths and constants of the planar twist odometry block.
// ----------------------------------------------------------------------------
package ptodo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int HEAD_W  = 16;
    localparam int POS_W   = 32;
    localparam int SPD_W   = 24;
    localparam int TRIG_W  = 34;
    localparam int MA_W    = 45;
    localparam int MB_W    = 34;
    localparam int ACC_W   = 80;
    localparam int NUM_W   = 60;
    localparam int DEN_W   = 46;
    localparam int QB      = 44;
    localparam int DIV_SH  = 14;
    localparam int FRAC_SH = 30;
    localparam int SUM_W   = ACC_W - FRAC_SH + 1;
    localparam int ADDR_W  = 4;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic [30:0]              PI_Q29   = 31'd1686629713;
    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (FRAC_SH - 1);

    localparam logic [31:0] ATAN_TBL [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    localparam logic [1:0] REG_START_HEADING = 2'd0;
    localparam logic [1:0] REG_START_X       = 2'd1;
    localparam logic [1:0] REG_START_Y       = 2'd2;

    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [HEAD_W-1:0] turn_rate;
        logic signed [SPD_W-1:0]  speed_x;
        logic signed [SPD_W-1:0]  speed_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [HEAD_W-1:0] pose_heading;
        logic signed [POS_W-1:0]  pose_x;
        logic signed [POS_W-1:0]  pose_y;
        logic                     saturated;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TURN, ST_M1, ST_M2, ST_DIV1, ST_M3, ST_M4, ST_DIV2,
        ST_HEAD, ST_M5, ST_M6, ST_UPD_X, ST_M7, ST_M8, ST_UPD_Y, ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/ptodo_cordic.sv =====
// ----------------------------------------------------------------------------
// ptodo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, sin/cos in Q30.
// ----------------------------------------------------------------------------
module ptodo_cordic #(
    parameter int STEPS = ptodo_pkg::CORDIC_STEPS_DEF,
    parameter int ABITS = ptodo_pkg::ANGLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [ptodo_pkg::HEAD_W-1:0]   i_angle,
    output logic                                  o_done,
    output logic signed [ptodo_pkg::TRIG_W-1:0]   o_sin,
    output logic signed [ptodo_pkg::TRIG_W-1:0]   o_cos
);
    import ptodo_pkg::*;

    localparam int CW = $clog2(STEPS);

    logic                     r_busy, r_done, r_neg;
    logic [CW-1:0]            r_i;
    logic signed [TRIG_W-1:0] r_x, r_y;
    logic signed [ABITS:0]    r_z;

    logic signed [HEAD_W:0]       w_a, w_af;
    logic                         w_neg;
    logic signed [ABITS+HEAD_W:0] w_ze, w_zs;
    logic signed [ABITS:0]        w_z0, w_t;
    logic [4:0]                   w_k;
    logic [31:0]                  w_tf;
    logic signed [TRIG_W-1:0]     w_xs, w_ys;

    always_comb begin
        w_a   = (HEAD_W+1)'(i_angle);
        w_af  = w_a;
        w_neg = 1'b0;
        if (w_a > 17'sd16384) begin
            w_af  = w_a - 17'sd32768;
            w_neg = 1'b1;
        end else if (w_a < -17'sd16384) begin
            w_af  = w_a + 17'sd32768;
            w_neg = 1'b1;
        end
    end

    assign w_ze = (ABITS+HEAD_W+1)'(w_af);

    generate
        if (ABITS >= HEAD_W) begin : g_up
            assign w_zs = w_ze <<< (ABITS - HEAD_W);
        end else begin : g_dn
            assign w_zs = w_ze >>> (HEAD_W - ABITS);
        end
    endgenerate

    assign w_z0 = signed'(w_zs[ABITS:0]);
    assign w_k  = 5'(r_i);
    assign w_tf = ATAN_TBL[w_k] >> (32 - ABITS);
    assign w_t  = signed'({1'b0, w_tf[ABITS-1:0]});
    assign w_xs = r_x >>> w_k;
    assign w_ys = r_y >>> w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= GAIN_Q30;
            r_y   <= '0;
            r_z   <= w_z0;
            r_i   <= '0;
            r_neg <= w_neg;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (!r_z[ABITS]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_t;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_t;
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_neg ? -r_y : r_y;
    assign o_cos  = r_neg ? -r_x : r_x;

endmodule

// ===== hw/rtl/ptodo_mac.sv =====
// ----------------------------------------------------------------------------
// ptodo_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ptodo_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptodo_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [ptodo_pkg::MA_W-1:0]    i_a,
    input  logic signed [ptodo_pkg::MB_W-1:0]    i_b,
    output logic                                 o_done,
    output logic signed [ptodo_pkg::ACC_W-1:0]   o_acc
);
    import ptodo_pkg::*;

    localparam int CW = $clog2(MB_W);

    logic                    r_busy, r_done, r_sub;
    logic [CW-1:0]           r_cnt;
    logic signed [ACC_W-1:0] r_acc, r_a;
    logic [MB_W-1:0]         r_b;
    logic                    w_last;

    assign w_last = (r_cnt == CW'(MB_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= ACC_W'(i_a);
            r_b   <= i_b;
            r_sub <= i_ctl.sub;
            r_cnt <= '0;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= (r_sub ^ w_last) ? r_acc - r_a : r_acc + r_a;
            end
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ===== hw/rtl/ptodo_div.sv =====
// ----------------------------------------------------------------------------
// ptodo_div
// Restoring divider for the arc step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptodo_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ptodo_pkg::NUM_W-1:0]   i_num,
    input  logic [ptodo_pkg::DEN_W-1:0]          i_den,
    input  logic                                 i_den_neg,
    output logic                                 o_done,
    output logic signed [ptodo_pkg::MA_W-1:0]    o_quo
);
    import ptodo_pkg::*;

    localparam int CW    = $clog2(QB);
    localparam int DVD_W = NUM_W + DIV_SH;

    logic              r_busy, r_done, r_neg;
    logic [CW-1:0]     r_cnt;
    logic [DEN_W-1:0]  r_rem, r_den;
    logic [QB-1:0]     r_sh;

    logic [NUM_W-1:0]  w_mag;
    logic [DVD_W-1:0]  w_dvd;
    logic [DEN_W:0]    w_t;
    logic              w_ge;
    logic              w_last;

    assign w_mag  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_dvd  = {w_mag, {DIV_SH{1'b0}}};
    assign w_t    = {r_rem, r_sh[QB-1]};
    assign w_ge   = (w_t >= {1'b0, r_den});
    assign w_last = (r_cnt == CW'(QB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(w_dvd[DVD_W-1:QB]);
            r_sh  <= w_dvd[QB-1:0];
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1] ^ i_den_neg;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : DEN_W'(w_t);
            r_sh  <= {r_sh[QB-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -signed'({1'b0, r_sh}) : signed'({1'b0, r_sh});

endmodule

// ===== hw/rtl/planar_twist_odometry_top.sv =====
// ----------------------------------------------------------------------------
// planar_twist_odometry_top
// Planar pose integrator: arc step from a body twist, rotated by heading.
//
//   channel   direction  handshake                 beat
//   in        input      i_in_valid / o_in_stall   t_in_beat
//   out       output     o_out_valid / i_out_stall t_out_beat
//   config    input      APB psel/penable/pwrite   start pose registers
//
// Restart and zero-twist beats go straight to the output load. A straight
// twist runs the heading CORDIC and the rotation multiplies; a turning one
// first runs a CORDIC of the turn rate, the arc multiplies and divides. The
// bit-serial multiplier and divider set the run time.
// Reset is synchronous and clears pose, start registers and control.
// A held result in the output register stalls only the final load.
// ----------------------------------------------------------------------------
module planar_twist_odometry_top #(
    parameter int CORDIC_STEPS = ptodo_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ptodo_pkg::ANGLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ptodo_pkg::t_in_beat            i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ptodo_pkg::t_out_beat           o_out_beat,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptodo_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import ptodo_pkg::*;

    t_state r_state, n_state;
    logic   r_entry;

    logic signed [HEAD_W-1:0] r_start_heading, r_heading, r_w;
    logic signed [POS_W-1:0]  r_start_x, r_start_y, r_pos_x, r_pos_y;
    logic signed [SPD_W-1:0]  r_vx, r_vy;
    logic [DEN_W-1:0]         r_den;
    logic signed [TRIG_W-1:0] r_s1, r_omc;
    logic signed [MA_W-1:0]   r_bx, r_by;
    logic                     r_sat;
    t_out_beat                r_out;
    logic                     r_out_valid;

    logic                     w_accept, w_zero, w_out_ok;
    logic [HEAD_W-1:0]        w_absw;
    logic [DEN_W:0]           w_prod;

    logic                     w_cor_start, w_cor_done;
    logic signed [HEAD_W-1:0] w_cor_angle;
    logic signed [TRIG_W-1:0] w_sin, w_cos;

    t_mac_ctl                 w_mac_ctl;
    logic signed [MA_W-1:0]   w_mac_a;
    logic signed [MB_W-1:0]   w_mac_b;
    logic                     w_mac_done;
    logic signed [ACC_W-1:0]  w_acc, w_rnd;

    logic                     w_div_start, w_div_done;
    logic signed [MA_W-1:0]   w_quo;

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [POS_W-1:0]  w_pos, w_pos_new;
    logic                     w_ovf;
    logic                     w_cfg_wr;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign w_zero   = (i_in_beat.turn_rate == '0) && (i_in_beat.speed_x == '0)
                      && (i_in_beat.speed_y == '0);
    assign w_out_ok = !r_out_valid || !i_out_stall;
    assign w_absw   = i_in_beat.turn_rate[HEAD_W-1] ? HEAD_W'(-i_in_beat.turn_rate)
                                                    : HEAD_W'(i_in_beat.turn_rate);
    assign w_prod   = (DEN_W+1)'(w_absw) * (DEN_W+1)'(PI_Q29);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_in_beat.cmd == CMD_RESTART || w_zero) begin
                        n_state = ST_OUT;
                    end else if (i_in_beat.turn_rate == '0) begin
                        n_state = ST_HEAD;
                    end else begin
                        n_state = ST_TURN;
                    end
                end
            end
            ST_TURN:  if (w_cor_done) n_state = ST_M1;
            ST_M1:    if (w_mac_done) n_state = ST_M2;
            ST_M2:    if (w_mac_done) n_state = ST_DIV1;
            ST_DIV1:  if (w_div_done) n_state = ST_M3;
            ST_M3:    if (w_mac_done) n_state = ST_M4;
            ST_M4:    if (w_mac_done) n_state = ST_DIV2;
            ST_DIV2:  if (w_div_done) n_state = ST_HEAD;
            ST_HEAD:  if (w_cor_done) n_state = ST_M5;
            ST_M5:    if (w_mac_done) n_state = ST_M6;
            ST_M6:    if (w_mac_done) n_state = ST_UPD_X;
            ST_UPD_X: n_state = ST_M7;
            ST_M7:    if (w_mac_done) n_state = ST_M8;
            ST_M8:    if (w_mac_done) n_state = ST_UPD_Y;
            ST_UPD_Y: n_state = ST_OUT;
            ST_OUT:   if (w_out_ok) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // unit control and operand select
    always_comb begin
        w_cor_start   = 1'b0;
        w_cor_angle   = r_w;
        w_mac_ctl     = '0;
        w_mac_a       = MA_W'(r_vx);
        w_mac_b       = r_s1;
        w_div_start   = 1'b0;
        unique case (r_state)
            ST_TURN: w_cor_start = r_entry;
            ST_HEAD: begin
                w_cor_start = r_entry;
                w_cor_angle = r_heading;
            end
            ST_M1: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b1, sub: 1'b0};
            end
            ST_M2: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b0, sub: 1'b1};
                w_mac_a   = MA_W'(r_vy);
                w_mac_b   = r_omc;
            end
            ST_M3: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b1, sub: 1'b0};
                w_mac_b   = r_omc;
            end
            ST_M4: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b0, sub: 1'b0};
                w_mac_a   = MA_W'(r_vy);
            end
            ST_M5: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b1, sub: 1'b0};
                w_mac_a   = r_bx;
                w_mac_b   = w_cos;
            end
            ST_M6: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b0, sub: 1'b1};
                w_mac_a   = r_by;
                w_mac_b   = w_sin;
            end
            ST_M7: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b1, sub: 1'b0};
                w_mac_a   = r_bx;
                w_mac_b   = w_sin;
            end
            ST_M8: begin
                w_mac_ctl = '{start: r_entry, clr: 1'b0, sub: 1'b0};
                w_mac_a   = r_by;
                w_mac_b   = w_cos;
            end
            ST_DIV1, ST_DIV2: w_div_start = r_entry;
            default: begin
            end
        endcase
    end

    ptodo_cordic #(
        .STEPS (CORDIC_STEPS),
        .ABITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_cor_angle),
        .o_done  (w_cor_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    ptodo_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    ptodo_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_num     (signed'(w_acc[NUM_W-1:0])),
        .i_den     (r_den),
        .i_den_neg (r_w[HEAD_W-1]),
        .o_done    (w_div_done),
        .o_quo     (w_quo)
    );

    // rounded step plus position, clipped to 32 bits
    assign w_rnd = w_acc + RND_HALF;
    assign w_pos = (r_state == ST_UPD_X) ? r_pos_x : r_pos_y;
    assign w_sum = SUM_W'(w_pos) + SUM_W'(signed'(w_rnd[ACC_W-1:FRAC_SH]));
    assign w_ovf = !((&w_sum[SUM_W-1:POS_W-1]) || !(|w_sum[SUM_W-1:POS_W-1]));
    assign w_pos_new = !w_ovf ? w_sum[POS_W-1:0]
                     : (w_sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                       : {1'b0, {(POS_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_entry <= (n_state != r_state);
            if (r_state == ST_OUT && w_out_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_heading <= '0;
            r_start_x       <= '0;
            r_start_y       <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_START_HEADING: r_start_heading <= pwdata[HEAD_W-1:0];
                REG_START_X:       r_start_x       <= pwdata;
                REG_START_Y:       r_start_y       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_HEADING: prdata = {{(32-HEAD_W){1'b0}}, r_start_heading};
            REG_START_X:       prdata = r_start_x;
            REG_START_Y:       prdata = r_start_y;
            default:           prdata = '0;
        endcase
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
        end else begin
            if (w_accept && i_in_beat.cmd == CMD_RESTART) begin
                r_heading <= r_start_heading;
                r_pos_x   <= r_start_x;
                r_pos_y   <= r_start_y;
            end
            if (r_state == ST_UPD_X) begin
                r_pos_x <= w_pos_new;
            end
            if (r_state == ST_UPD_Y) begin
                r_pos_y   <= w_pos_new;
                r_heading <= r_heading + r_w;
            end
        end
    end

    // working operands
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_w   <= i_in_beat.turn_rate;
            r_vx  <= i_in_beat.speed_x;
            r_vy  <= i_in_beat.speed_y;
            r_den <= w_prod[DEN_W-1:0];
            r_sat <= 1'b0;
            r_bx  <= MA_W'(i_in_beat.speed_x);
            r_by  <= MA_W'(i_in_beat.speed_y);
        end
        if (r_state == ST_TURN && w_cor_done) begin
            r_s1  <= w_sin;
            r_omc <= ONE_Q30 - w_cos;
        end
        if (r_state == ST_DIV1 && w_div_done) begin
            r_bx <= w_quo;
        end
        if (r_state == ST_DIV2 && w_div_done) begin
            r_by <= w_quo;
        end
        if (r_state == ST_UPD_X || r_state == ST_UPD_Y) begin
            r_sat <= r_sat | w_ovf;
        end
        if (r_state == ST_OUT && w_out_ok) begin
            r_out.pose_heading <= r_heading;
            r_out.pose_x       <= r_pos_x;
            r_out.pose_y       <= r_pos_y;
            r_out.saturated    <= r_sat;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the planar twist odometry block against a bit-true pose predictor.
// A queue-fed driver sends integrate and restart beats, a monitor compares
// each result beat with the oldest predicted pose; start pose registers are
// written over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import ptodo_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_beat            in_beat = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_beat           out_beat;
    logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    planar_twist_odometry_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_beat(in_beat),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_beat(out_beat),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    t_in_beat   pending_beats[$];
    t_out_beat  expected_poses[$];
    int         send_idle_pct = 0, recv_idle_pct = 0;
    int         errors = 0, beats_sent = 0, beats_checked = 0;
    int         restarts = 0, sat_hits = 0, quiet_cycles = 0;
    bit         in_taken = 1'b0;
    localparam int QUIET_LIMIT = 20000;

    logic signed [15:0] st_head = 0, pose_head = 0;
    logic signed [31:0] st_x = 0, st_y = 0, pose_x = 0, pose_y = 0;

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x, y, z, nx, t;
        bit flip;
        x = 652032874; y = 0; flip = 0;
        if (ang > 16384) begin ang -= 32768; flip = 1; end
        else if (ang < -16384) begin ang += 32768; flip = 1; end
        z = ang;
        for (int i = 0; i < 16; i++) begin
            t = longint'(ATAN_TBL[i] >> 16);
            if (z >= 0) begin
                nx = x - shr(y, i); y = y + shr(x, i); z -= t;
            end else begin
                nx = x + shr(y, i); y = y - shr(x, i); z += t;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint arc_quot(longint num, longint w);
        bit neg;
        logic [63:0] n, d, q, r, res;
        neg = (num < 0) != (w < 0);
        n = num < 0 ? -num : num;
        d = 64'(w < 0 ? -w : w) * 64'd1686629713;
        q = n / d; r = n % d;
        res = (q << 14) + ((r << 14) / d);
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint clip32(longint v, inout bit hit);
        if (v > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
        return v;
    endfunction

    task automatic predict_pose(input t_in_beat b);
        t_out_beat r;
        longint w, vx, vy, bx, by, sw, cw, omc, sh, ch, dx, dy;
        bit hit;
        hit = 0;
        if (b.cmd == CMD_RESTART) begin
            pose_head = st_head; pose_x = st_x; pose_y = st_y;
        end else begin
            w = b.turn_rate; vx = b.speed_x; vy = b.speed_y;
            if (w != 0 || vx != 0 || vy != 0) begin
                if (w == 0) begin
                    bx = vx; by = vy;
                end else begin
                    cordic_sincos(w, sw, cw);
                    omc = 64'sd1073741824 - cw;
                    bx = arc_quot(vx * sw - vy * omc, w);
                    by = arc_quot(vx * omc + vy * sw, w);
                end
                cordic_sincos(longint'(pose_head), sh, ch);
                dx = (ch * bx - sh * by + (64'sd1 << 29)) >>> 30;
                dy = (sh * bx + ch * by + (64'sd1 << 29)) >>> 30;
                pose_x = 32'(clip32(longint'(pose_x) + dx, hit));
                pose_y = 32'(clip32(longint'(pose_y) + dy, hit));
                pose_head = 16'(longint'(pose_head) + w);
            end
        end
        r.pose_heading = pose_head; r.pose_x = pose_x; r.pose_y = pose_y;
        r.saturated = hit;
        expected_poses.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d want %0d", beats_checked, what, got, want);
        errors++;
    endtask

    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        in_taken = in_valid && !in_stall;
        if (rst_n) begin
            if (in_taken) begin
                predict_pose(in_beat);
                beats_sent++;
            end
            if (out_valid && !out_stall) begin
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    t_out_beat e;
                    e = expected_poses.pop_front();
                    if (out_beat.pose_heading !== e.pose_heading)
                        report_mismatch("heading", out_beat.pose_heading, e.pose_heading);
                    if (out_beat.pose_x !== e.pose_x)
                        report_mismatch("x", out_beat.pose_x, e.pose_x);
                    if (out_beat.pose_y !== e.pose_y)
                        report_mismatch("y", out_beat.pose_y, e.pose_y);
                    if (out_beat.saturated !== e.saturated)
                        report_mismatch("saturated", out_beat.saturated, e.saturated);
                    if (e.saturated) sat_hits++;
                end
                beats_checked++;
            end
            if (in_taken || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_START_HEADING: st_head = val[15:0];
            REG_START_X:       st_x = val;
            REG_START_Y:       st_y = val;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_start(input logic [15:0] h, input logic [31:0] x, input logic [31:0] y);
        apb_write(REG_START_HEADING, {16'd0, h});
        apb_write(REG_START_X, x);
        apb_write(REG_START_Y, y);
    endtask

    task automatic drain;
        while (pending_beats.size() > 0 || in_valid || expected_poses.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic t_in_beat twist(int w, int vx, int vy);
        t_in_beat b;
        b.cmd = 1'b0; b.turn_rate = 16'(w); b.speed_x = 24'(vx); b.speed_y = 24'(vy);
        return b;
    endfunction

    function automatic t_in_beat restart_beat();
        t_in_beat b;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.cmd = CMD_RESTART;
        return b;
    endfunction

    function automatic int rand_turn();
        case ($urandom_range(5))
            0: return 0;
            1: return $urandom_range(1, 64) * ($urandom_range(1) ? 1 : -1);
            2: return ($urandom_range(1) ? 32767 : -32768);
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int rand_speed();
        case ($urandom_range(4))
            0: return 0;
            1: return ($urandom_range(1) ? 8388607 : -8388608);
            2: return int'($signed(24'($urandom))) >>> $urandom_range(16);
            default: return int'($signed(24'($urandom)));
        endcase
    endfunction

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(29) == 0) begin
                pending_beats.push_back(restart_beat());
                restarts++;
            end else begin
                pending_beats.push_back(twist(rand_turn(), rand_speed(), rand_speed()));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero twist, straight, turning, restart, overflow
        pending_beats.push_back(twist(0, 0, 0));
        pending_beats.push_back(twist(0, 8388607, 0));
        pending_beats.push_back(twist(0, 0, -8388608));
        pending_beats.push_back(twist(16384, 65536, 0));
        pending_beats.push_back(twist(-32768, 8388607, 8388607));
        pending_beats.push_back(twist(32767, -8388608, -8388608));
        pending_beats.push_back(twist(1, 8388607, -8388608));
        pending_beats.push_back(twist(-1, -8388608, 8388607));
        pending_beats.push_back(twist(16385, 1000, -1000));
        pending_beats.push_back(twist(-16385, 0, 0));
        pending_beats.push_back(restart_beat());
        restarts++;
        for (int i = 0; i < 6; i++) pending_beats.push_back(twist(0, 8388607, 8388607));
        drain();

        set_start(16'h8000, 32'h7FFF0000, 32'h80010000);
        pending_beats.push_back(restart_beat());
        for (int i = 0; i < 4; i++) pending_beats.push_back(twist(8192, -8388608, 8388607));
        pending_beats.push_back(twist(0, 0, 0));
        pending_beats.push_back(restart_beat());
        restarts += 2;
        drain();

        send_idle_pct = 31; recv_idle_pct = 64;
        set_start(16'h7FFF, 32'h80000000, 32'h7FFFFFFF);
        queue_random(600);
        drain();

        send_idle_pct = 64; recv_idle_pct = 31;
        set_start(16'($urandom), $urandom, $urandom);
        queue_random(600);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        set_start(16'h0000, 32'h00000000, 32'h00000000);
        queue_random(600);
        drain();

        $display("covered %0d beats in, %0d results checked, %0d restarts, %0d clipped",
                 beats_sent, beats_checked, restarts, sat_hits);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ptodo_pkg.sv
hw/rtl/ptodo_cordic.sv
hw/rtl/ptodo_mac.sv
hw/rtl/ptodo_div.sv
hw/rtl/planar_twist_odometry_top.sv
tb/sv/testbench.sv
